// ===== src/rdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    // Base clamp limits and ASCII anchors
    localparam logic [5:0] BASE_MIN      = 6'd2;
    localparam logic [5:0] BASE_MAX      = 6'd36;
    localparam logic [5:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic store;
        logic emit_next;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic q_zero;
        logic div_last;
        logic emit_last;
    } sts_t;

    // Remainder to ASCII digit: '0'..'9', then 'A' onward
    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] d7;
        d7 = {1'b0, d};
        if (d < DECIMAL_LIMIT)
            return ASCII_ZERO + d7;
        return ASCII_UPPER_A + d7 - {1'b0, DECIMAL_LIMIT};
    endfunction

endpackage

`default_nettype wire

// ===== src/rdc_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_controller
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             req_valid,
    output logic            req_stall,
    output logic            char_valid,
    input  wire             char_stall,
    input  rdc_pkg::sts_t   sts,
    output rdc_pkg::cmd_t   cmd
);

    rdc_pkg::state_t state_reg;
    rdc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rdc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        char_valid = 1'b0;
        unique case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rdc_pkg::ST_CHECK;
                end
            end
            rdc_pkg::ST_CHECK:
            begin
                // quotient exhausted: field is complete
                if (sts.q_zero)
                    state_next = rdc_pkg::ST_EMIT;
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = rdc_pkg::ST_DIV;
                end
            end
            rdc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = rdc_pkg::ST_STORE;
            end
            rdc_pkg::ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = rdc_pkg::ST_CHECK;
            end
            rdc_pkg::ST_EMIT:
            begin
                char_valid = 1'b1;
                if (!char_stall)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last)
                        state_next = rdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rdc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_datapath
#(
    parameter int FIELD_DIGITS = 7,
    parameter int VALUE_WIDTH  = 32,
    localparam int QW    = VALUE_WIDTH - 1,
    localparam int POS_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1,
    localparam int CNT_W = $clog2(QW)
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  [VALUE_WIDTH-1:0]  value,
    input  wire  [5:0]              base,
    input  rdc_pkg::cmd_t           cmd,
    output rdc_pkg::sts_t           sts,
    output logic [6:0]              digit_char,
    output logic [POS_W-1:0]        position,
    output logic                    overflow,
    output logic                    last
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_DIGITS - 1);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(QW - 1);

    logic [QW-1:0]    quotient_reg;
    logic [QW-1:0]    quotient_next;
    logic [5:0]       base_reg;
    logic [5:0]       base_next;
    logic [5:0]       rem_reg;
    logic [5:0]       rem_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic [POS_W-1:0] fill_reg;
    logic [POS_W-1:0] fill_next;
    logic             full_reg;
    logic             full_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [POS_W-1:0] emit_reg;
    logic [POS_W-1:0] emit_next;
    logic [6:0]       char_store_reg [FIELD_DIGITS];

    logic [6:0]       trial;
    logic             fits;
    logic [6:0]       trial_sub;

    // One restoring division step: shift in the next quotient bit
    always_comb
    begin
        trial     = {rem_reg, quotient_reg[QW-1]};
        fits      = (trial >= {1'b0, base_reg});
        trial_sub = trial - {1'b0, base_reg};
    end

    // Next values of the working registers
    always_comb
    begin
        quotient_next = quotient_reg;
        base_next     = base_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        fill_next     = fill_reg;
        full_next     = full_reg;
        ovf_next      = ovf_reg;
        emit_next     = emit_reg;
        priority if (cmd.load)
        begin
            // negative values convert as zero
            quotient_next = value[VALUE_WIDTH-1] ? '0 : value[QW-1:0];
            if (base < rdc_pkg::BASE_MIN)
                base_next = rdc_pkg::BASE_MIN;
            else if (base > rdc_pkg::BASE_MAX)
                base_next = rdc_pkg::BASE_MAX;
            else
                base_next = base;
            fill_next = POS_LAST;
            full_next = 1'b0;
            ovf_next  = 1'b0;
            emit_next = '0;
        end
        else if (cmd.div_init)
        begin
            rem_next  = '0;
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next      = fits ? trial_sub[5:0] : trial[5:0];
            quotient_next = {quotient_reg[QW-2:0], fits};
            step_next     = step_reg + CNT_W'(1);
        end
        else if (cmd.store)
        begin
            // keep the low-order digits, flag the rest
            if (full_reg)
                ovf_next = 1'b1;
            else if (fill_reg == '0)
                full_next = 1'b1;
            else
                fill_next = fill_reg - POS_W'(1);
        end
        else if (cmd.emit_next)
        begin
            emit_next = (emit_reg == POS_LAST) ? '0 : emit_reg + POS_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            fill_reg <= POS_LAST;
            full_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            emit_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            fill_reg <= fill_next;
            full_reg <= full_next;
            ovf_reg  <= ovf_next;
            emit_reg <= emit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
        base_reg     <= base_next;
        rem_reg      <= rem_next;
    end

    // Character field: cleared per item, written right to left
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < FIELD_DIGITS; i++)
                char_store_reg[i] <= '0;
        end
        else if (cmd.store && !full_reg)
        begin
            char_store_reg[fill_reg] <= rdc_pkg::digit_to_ascii(rem_reg);
        end
    end

    // Status and result fields
    always_comb
    begin
        sts.q_zero    = (quotient_reg == '0);
        sts.div_last  = (step_reg == STEP_LAST);
        sts.emit_last = (emit_reg == POS_LAST);
        digit_char    = char_store_reg[emit_reg];
        position      = emit_reg;
        overflow      = ovf_reg;
        last          = (emit_reg == POS_LAST);
    end

endmodule

`default_nettype wire

// ===== src/radix_digit_converter.sv =====
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+-----------------------------
//  req     | req_valid req_stall value base   | in        | integer and radix
//  char    | char_valid char_stall digit_char | out       | one character of the field,
//          | position overflow last           |           | FIELD_DIGITS items per req
//
//  Each digit takes one check, VALUE_WIDTH - 1 steps of the bit-serial divider
//  and one store. Zero and negative values have no digits. One item is worked
//  on at a time; req_stall stays high until the last character is taken. Reset
//  is asynchronous, active low, and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter
#(
    parameter int FIELD_DIGITS = 7,
    parameter int VALUE_WIDTH  = 32,
    localparam int POS_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_stall,
    input  wire  [VALUE_WIDTH-1:0]  value,
    input  wire  [5:0]              base,
    output logic                    char_valid,
    input  wire                     char_stall,
    output logic [6:0]              digit_char,
    output logic [POS_W-1:0]        position,
    output logic                    overflow,
    output logic                    last
);

    rdc_pkg::cmd_t cmd;
    rdc_pkg::sts_t sts;

    // Sequencer
    rdc_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Divider, digit field and result fields
    rdc_datapath
    #(
        .FIELD_DIGITS (FIELD_DIGITS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .base       (base),
        .cmd        (cmd),
        .sts        (sts),
        .digit_char (digit_char),
        .position   (position),
        .overflow   (overflow),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== src/rdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker
#(
    parameter int FIELD_DIGITS = 7,
    parameter int VALUE_WIDTH  = 32,
    localparam int POS_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1
)
(
    input wire                     clk,
    input wire                     rst_n,
    input wire                     req_valid,
    input wire                     req_stall,
    input wire  [VALUE_WIDTH-1:0]  value,
    input wire  [5:0]              base,
    input wire                     char_valid,
    input wire                     char_stall,
    input wire  [6:0]              digit_char,
    input wire  [POS_W-1:0]        position,
    input wire                     overflow,
    input wire                     last
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_DIGITS - 1);

    // No new item is taken while characters are going out
    a_busy_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> req_stall)
        else $error("req accepted while characters pending");

    // A stalled request holds its payload until taken
    a_req_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall) |=>
            (req_valid && $stable(value) && $stable(base)))
        else $error("stalled request changed");

    // last marks exactly the rightmost position
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (last == (position == POS_LAST)))
        else $error("last flag does not match position");

    // Characters of one field follow without a gap, positions counting up
    a_field_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && !last) |=>
            (char_valid && position == $past(position) + POS_W'(1)))
        else $error("field interrupted or position skipped");

    // A stalled character holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=>
            (char_valid && $stable(digit_char) && $stable(overflow)))
        else $error("stalled character changed");

endmodule

bind radix_digit_converter rdc_checker
#(
    .FIELD_DIGITS (FIELD_DIGITS),
    .VALUE_WIDTH  (VALUE_WIDTH)
)
u_rdc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .value      (value),
    .base       (base),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .digit_char (digit_char),
    .position   (position),
    .overflow   (overflow),
    .last       (last)
);

`default_nettype wire

// ===== tb/sv/radix_digit_converter_tb.sv =====
`timescale 1ns / 1ps

module radix_digit_converter_tb;

    localparam int FIELD_DIGITS = 7;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 20;

    // One character of the output field as the predictor sees it
    typedef struct {
        logic [6:0] ch;
        logic [2:0] pos;
        logic       ovf;
        logic       lst;
    } char_exp_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [31:0] value;
    logic [5:0]  base;
    logic        char_valid;
    logic        char_stall;
    logic [6:0]  digit_char;
    logic [2:0]  position;
    logic        overflow;
    logic        last;

    char_exp_t expected_chars[$];
    int        err_count     = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    radix_digit_converter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .value      (value),
        .base       (base),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .digit_char (digit_char),
        .position   (position),
        .overflow   (overflow),
        .last       (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Convert one value and queue its seven characters, leftmost first
    function automatic void push_field(input logic [31:0] v, input logic [5:0] b);
        logic [6:0]  field [FIELD_DIGITS];
        logic [31:0] q;
        logic [31:0] r;
        int unsigned radix;
        int          filled;
        int          idx;
        logic        ovf;
        char_exp_t   c;
        radix = b;
        if (radix < rdc_pkg::BASE_MIN)
            radix = rdc_pkg::BASE_MIN;
        if (radix > rdc_pkg::BASE_MAX)
            radix = rdc_pkg::BASE_MAX;
        for (int k = 0; k < FIELD_DIGITS; k++)
            field[k] = 7'd0;
        // negative values convert as zero
        q      = v[31] ? 32'd0 : v;
        filled = 0;
        idx    = FIELD_DIGITS - 1;
        ovf    = 1'b0;
        while (q != 0)
        begin
            r = q % radix;
            q = q / radix;
            if (filled < FIELD_DIGITS)
            begin
                if (r < rdc_pkg::DECIMAL_LIMIT)
                    field[idx] = rdc_pkg::ASCII_ZERO + 7'(r);
                else
                    field[idx] = rdc_pkg::ASCII_UPPER_A + 7'(r)
                                 - 7'(rdc_pkg::DECIMAL_LIMIT);
                filled++;
                if (idx > 0)
                    idx--;
            end
            else
            begin
                ovf = 1'b1;
            end
        end
        for (int k = 0; k < FIELD_DIGITS; k++)
        begin
            c.ch  = field[k];
            c.pos = 3'(k);
            c.ovf = ovf;
            c.lst = (k == FIELD_DIGITS - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // Receiver stall, redrawn every cycle
    always @(negedge clk)
        char_stall <= ($urandom_range(99) < recv_idle_pct);

    // Predict on each accepted request, check each accepted character
    always @(posedge clk)
    begin : char_check
        char_exp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                push_field(value, base);
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"unexpected char: digit_char=%0h position=%0d",
                                  " overflow=%0b last=%0b"},
                                 digit_char, position, overflow, last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (digit_char !== want.ch || position !== want.pos ||
                        overflow !== want.ovf || last !== want.lst)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"mismatch: exp char=%0h pos=%0d ovf=%0b last=%0b,",
                                      " got char=%0h pos=%0d ovf=%0b last=%0b"},
                                     want.ch, want.pos, want.ovf, want.lst,
                                     digit_char, position, overflow, last);
                    end
                end
            end
        end
    end

    // Present one request and hold it until taken; called and returns on a falling edge
    task automatic send_item(input logic [31:0] v, input logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        value     <= v;
        base      <= b;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Zero, negative and most-negative values give an all-NUL field
    task automatic test_zero_and_negative();
        send_item(32'd0, 6'd10);
        send_item(32'hFFFF_FFFF, 6'd10);
        send_item(32'h8000_0000, 6'd2);
        send_item(-32'sd12345, 6'd16);
    endtask

    // Bases below two and above thirty-six are clamped
    task automatic test_base_clamp();
        send_item(32'd255, 6'd0);
        send_item(32'd255, 6'd1);
        send_item(32'd255, 6'd2);
        send_item(32'd1295, 6'd36);
        send_item(32'd1295, 6'd37);
        send_item(32'd63, 6'h3F);
    endtask

    // Digit letters, exact field fills and too many digits
    task automatic test_digit_range();
        send_item(32'd35, 6'd36);
        send_item(32'd9, 6'd10);
        send_item(32'd10, 6'd11);
        send_item(32'd1, 6'd2);
        send_item(32'd1234567, 6'd10);
        send_item(32'd12345678, 6'd10);
        send_item(32'd127, 6'd2);
        send_item(32'd128, 6'd2);
        send_item(32'h7FFF_FFFF, 6'd2);
        send_item(32'h7FFF_FFFF, 6'd10);
        send_item(32'h7FFF_FFFF, 6'd36);
    endtask

    // Mixed random values: negatives, full-range positives and short numbers
    task automatic test_random_values(input int count);
        logic [31:0] v;
        logic [5:0]  b;
        int          pick;
        repeat (count)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                v = $urandom | 32'h8000_0000;
            else if (pick < 6)
                v = $urandom & 32'h7FFF_FFFF;
            else
                v = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(30);
            if ($urandom_range(9) == 0)
                b = 6'($urandom);
            else
                b = 6'($urandom_range(rdc_pkg::BASE_MAX, rdc_pkg::BASE_MIN));
            send_item(v, b);
        end
    endtask

    // Hard stop if the block hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        value      = 32'd0;
        base       = 6'd0;
        char_stall = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 76;
        test_zero_and_negative();
        test_base_clamp();
        test_digit_range();
        test_random_values(80);

        send_idle_pct = 76;
        recv_idle_pct = 21;
        test_random_values(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_values(90);
        req_valid <= 1'b0;

        // drain, then watch for stray characters
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_count == 0 && expected_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
